### rtl/plct_pkg.sv
// plct_pkg: shared constants and result type for the paged lru cache tracker
// no dependencies; used by the interfaces, the page divider, the lru core and the top level
`default_nettype none

package plct_pkg;

    // default sizes of the block
    localparam int WAYS_DEF       = 8;
    localparam int PAGE_ITEMS_DEF = 10;
    localparam int INDEX_BITS_DEF = 16;

    // configuration register
    localparam int              CFG_W          = 4;
    localparam logic [CFG_W-1:0] CACHE_WAYS_RST = 4'd8;

    // width of reported page numbers
    localparam int PAGE_OUT_W = 13;

    // one result word
    typedef struct packed {
        logic                  hit;
        logic [PAGE_OUT_W-1:0] page_number;
        logic                  evicted;
        logic [PAGE_OUT_W-1:0] evicted_page;
    } result_t;

endpackage

`default_nettype wire

### rtl/plct_if.sv
// plct_if: valid/ready channel interfaces for request and result words
// depends on plct_pkg for default widths
`default_nettype none

interface plct_item_if #(
    parameter int INDEX_BITS = plct_pkg::INDEX_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] item_index;

    modport source (output valid, output item_index, input ready);
    modport sink   (input valid, input item_index, output ready);
endinterface

interface plct_result_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [plct_pkg::PAGE_OUT_W-1:0] page_number;
    logic                            evicted;
    logic [plct_pkg::PAGE_OUT_W-1:0] evicted_page;

    modport source (output valid, output hit, output page_number, output evicted,
                    output evicted_page, input ready);
    modport sink   (input valid, input hit, input page_number, input evicted,
                    input evicted_page, output ready);
endinterface

`default_nettype wire

### rtl/paged_lru_cache_tracker_top.sv
// paged_lru_cache_tracker_top: page divider feeding a fully associative lru tracker
// depends on plct_pkg, plct_if, plct_page_div and plct_lru_core
//
//   channel  | dir | payload                                         | handshake
//   ---------+-----+-------------------------------------------------+------------
//   item     | in  | item_index                                      | valid/ready
//   result   | out | hit, page_number, evicted, evicted_page         | valid/ready
//   cfg      | in  | cfg_wdata -> cache_ways                         | cfg_we
//
// one word accepted per cycle while the result channel is not stalled; a result word
// passes index register, quotient estimate, page register, lookup into result register
// the lookup and age/tag update are combinational, registered with the result register
// reset clears all valid bits, ages and the occupancy count; cache_ways resets to 8
// a stalled result stalls the stages behind it only as far as they are full
`default_nettype none

module paged_lru_cache_tracker_top #(
    parameter int WAYS       = plct_pkg::WAYS_DEF,
    parameter int PAGE_ITEMS = plct_pkg::PAGE_ITEMS_DEF,
    parameter int INDEX_BITS = plct_pkg::INDEX_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    plct_item_if.sink                       item,
    plct_result_if.source                   result,
    input  wire logic                       cfg_we,
    input  wire logic [plct_pkg::CFG_W-1:0] cfg_wdata
);
    localparam int CNT_W = $clog2(WAYS + 1);

    logic [plct_pkg::CFG_W-1:0] cache_ways_reg;
    logic                       page_valid, page_ready;
    logic [INDEX_BITS-1:0]      page;
    logic [CNT_W-1:0]           occupancy;
    logic [WAYS-1:0]            way_valid_vec;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_ways_reg <= plct_pkg::CACHE_WAYS_RST;
        end
        else if (cfg_we)
        begin
            cache_ways_reg <= cfg_wdata;
        end
    end

    // item index to page number
    plct_page_div #(
        .INDEX_BITS (INDEX_BITS),
        .PAGE_ITEMS (PAGE_ITEMS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .page_valid (page_valid),
        .page_ready (page_ready),
        .page       (page)
    );

    // lookup, replacement and result register
    plct_lru_core #(
        .WAYS       (WAYS),
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cache_ways    (cache_ways_reg),
        .page_valid    (page_valid),
        .page_ready    (page_ready),
        .page          (page),
        .result        (result),
        .occupancy     (occupancy),
        .way_valid_vec (way_valid_vec)
    );

`ifndef SYNTHESIS
    // an eviction only happens on a miss
    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.evicted |-> !result.hit)
        else $error("eviction reported on a hit");

    // evicted page field reads zero when nothing was evicted
    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.evicted |-> result.evicted_page == '0)
        else $error("evicted_page nonzero without eviction");

    // occupancy count tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(way_valid_vec) == int'(occupancy))
        else $error("occupancy count out of step with valid bits");

    // evictions replace in place, so occupancy never falls
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> occupancy >= $past(occupancy))
        else $error("occupancy decreased");
`endif

endmodule

`default_nettype wire

### rtl/plct_page_div.sv
// plct_page_div: three-stage pipeline turning an item index into a page number
// depends on plct_pkg and plct_item_if
`default_nettype none

module plct_page_div #(
    parameter int INDEX_BITS = plct_pkg::INDEX_BITS_DEF,
    parameter int PAGE_ITEMS = plct_pkg::PAGE_ITEMS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    plct_item_if.sink           item,
    output logic                page_valid,
    input  wire logic           page_ready,
    output logic [INDEX_BITS-1:0] page
);
    // reciprocal of the page size scaled by 2^INDEX_BITS, rounded down
    localparam int RECIP_W = INDEX_BITS + 1;
    localparam longint unsigned RECIP_FULL = (64'd1 << INDEX_BITS) / 64'(PAGE_ITEMS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int PROD_W  = INDEX_BITS + RECIP_W;
    localparam int PI_W    = $clog2(PAGE_ITEMS + 1);
    localparam int BACK_W  = INDEX_BITS + PI_W;
    localparam int REM_W   = (INDEX_BITS > PI_W) ? INDEX_BITS : PI_W;

    logic                  v0_reg, v1_reg, v2_reg;
    logic [INDEX_BITS-1:0] idx0_reg, idx1_reg;
    logic [INDEX_BITS-1:0] quo1_reg, page2_reg;
    logic                  rdy0, rdy1, rdy2;
    logic [PROD_W-1:0]     prod;
    logic [INDEX_BITS-1:0] quo_est;
    logic [BACK_W-1:0]     back_full;
    logic [INDEX_BITS-1:0] rem;
    logic [INDEX_BITS-1:0] page_next;

    // stage ready chain
    assign rdy2       = !v2_reg || page_ready;
    assign rdy1       = !v1_reg || rdy2;
    assign rdy0       = !v0_reg || rdy1;
    assign item.ready = rdy0;

    // quotient estimate, low by at most one
    always_comb
    begin
        prod    = PROD_W'(idx0_reg) * PROD_W'(RECIP);
        quo_est = INDEX_BITS'(prod >> INDEX_BITS);
    end

    // remainder check and correction
    always_comb
    begin
        back_full = BACK_W'(quo1_reg) * BACK_W'(PAGE_ITEMS);
        rem       = idx1_reg - INDEX_BITS'(back_full);
        if (REM_W'(rem) >= REM_W'(PAGE_ITEMS))
        begin
            page_next = quo1_reg + INDEX_BITS'(1);
        end
        else
        begin
            page_next = quo1_reg;
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= item.valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            idx0_reg <= item.item_index;
        end
        if (rdy1)
        begin
            idx1_reg <= idx0_reg;
            quo1_reg <= quo_est;
        end
        if (rdy2)
        begin
            page2_reg <= page_next;
        end
    end

    assign page_valid = v2_reg;
    assign page       = page2_reg;

endmodule

`default_nettype wire

### rtl/plct_lru_core.sv
// plct_lru_core: way tags, ages and valid bits; one lookup and update per cycle while the result is not stalled
// depends on plct_pkg and plct_result_if
`default_nettype none

module plct_lru_core #(
    parameter int WAYS       = plct_pkg::WAYS_DEF,
    parameter int INDEX_BITS = plct_pkg::INDEX_BITS_DEF,
    localparam int CNT_W     = $clog2(WAYS + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [plct_pkg::CFG_W-1:0] cache_ways,
    input  wire logic                       page_valid,
    output logic                            page_ready,
    input  wire logic [INDEX_BITS-1:0]      page,
    plct_result_if.source                   result,
    output logic [CNT_W-1:0]                occupancy,
    output logic [WAYS-1:0]                 way_valid_vec
);
    localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CMP_W = (CNT_W > plct_pkg::CFG_W) ? CNT_W : plct_pkg::CFG_W;

    logic [INDEX_BITS-1:0] way_page_reg [WAYS];
    logic [WAYS-1:0]       way_valid_reg, way_valid_next;
    logic [AGE_W-1:0]      way_age_reg [WAYS];
    logic [AGE_W-1:0]      way_age_next [WAYS];
    logic [CNT_W-1:0]      count_reg, count_next;
    plct_pkg::result_t     res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;

    logic                  lookup;
    logic [WAYS-1:0]       match, old_vec;
    logic                  hit_any, full, evict;
    logic [AGE_W-1:0]      found_idx, victim_idx, free_idx, target_idx;
    logic [AGE_W-1:0]      hit_age, oldest_age;
    logic [CMP_W-1:0]      cfg_ext, cap;

    assign page_ready = !res_valid_reg || result.ready;
    assign lookup     = page_valid && page_ready;

    // tag compare and oldest-rank search, one per way
    always_comb
    begin
        oldest_age = AGE_W'(count_reg - CNT_W'(1));
        for (int w = 0; w < WAYS; w++)
        begin
            match[w]   = way_valid_reg[w] && (way_page_reg[w] == page);
            old_vec[w] = way_valid_reg[w] && (way_age_reg[w] == oldest_age);
        end
        hit_any = |match;
    end

    // lowest-numbered matching, oldest and free ways
    always_comb
    begin
        found_idx  = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                found_idx = AGE_W'(w);
            end
            if (old_vec[w])
            begin
                victim_idx = AGE_W'(w);
            end
            if (!way_valid_reg[w])
            begin
                free_idx = AGE_W'(w);
            end
        end
        hit_age = way_age_reg[found_idx];
    end

    // effective capacity: zero acts as one, saturate at the way count
    always_comb
    begin
        cfg_ext = CMP_W'(cache_ways);
        if (cfg_ext == '0)
        begin
            cap = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(WAYS))
        begin
            cap = CMP_W'(WAYS);
        end
        else
        begin
            cap = cfg_ext;
        end
        full       = CMP_W'(count_reg) >= cap;
        evict      = !hit_any && full;
        target_idx = evict ? victim_idx : free_idx;
    end

    // next ages, valid bits and occupancy
    always_comb
    begin
        way_valid_next = way_valid_reg;
        count_next     = count_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            way_age_next[w] = way_age_reg[w];
        end
        if (lookup)
        begin
            if (hit_any)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (way_valid_reg[w] && (way_age_reg[w] < hit_age))
                    begin
                        way_age_next[w] = way_age_reg[w] + AGE_W'(1);
                    end
                end
                way_age_next[found_idx] = '0;
            end
            else
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (way_valid_reg[w])
                    begin
                        way_age_next[w] = way_age_reg[w] + AGE_W'(1);
                    end
                end
                way_age_next[target_idx]   = '0;
                way_valid_next[target_idx] = 1'b1;
                if (!evict)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    // result word
    always_comb
    begin
        res_next.hit          = hit_any;
        res_next.page_number  = plct_pkg::PAGE_OUT_W'(page);
        res_next.evicted      = evict;
        res_next.evicted_page = evict ? plct_pkg::PAGE_OUT_W'(way_page_reg[victim_idx]) : '0;
        if (lookup)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            way_valid_reg <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int w = 0; w < WAYS; w++)
            begin
                way_age_reg[w] <= '0;
            end
        end
        else
        begin
            way_valid_reg <= way_valid_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            for (int w = 0; w < WAYS; w++)
            begin
                way_age_reg[w] <= way_age_next[w];
            end
        end
    end

    // tags and result payload
    always_ff @(posedge clk)
    begin
        if (lookup)
        begin
            res_reg <= res_next;
            if (!hit_any)
            begin
                way_page_reg[target_idx] <= page;
            end
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.hit          = res_reg.hit;
    assign result.page_number  = res_reg.page_number;
    assign result.evicted      = res_reg.evicted;
    assign result.evicted_page = res_reg.evicted_page;

    assign occupancy     = count_reg;
    assign way_valid_vec = way_valid_reg;

endmodule

`default_nettype wire

### tb/sv/paged_lru_cache_tracker_top_tb.sv
// paged_lru_cache_tracker_top_tb: self-checking bench for the paged lru cache tracker
// depends on plct_pkg, plct_if and the rtl under rtl/; checks every result word
// against a behavioral lru page tracker kept in the bench
`timescale 1ns / 100ps

module paged_lru_cache_tracker_top_tb;

    localparam int WAYS        = plct_pkg::WAYS_DEF;
    localparam int PAGE_ITEMS  = plct_pkg::PAGE_ITEMS_DEF;
    localparam int INDEX_BITS  = plct_pkg::INDEX_BITS_DEF;
    localparam int MAX_INDEX   = (1 << INDEX_BITS) - 1;
    localparam int MAX_PAGE    = MAX_INDEX / PAGE_ITEMS;
    localparam int DRAIN_WAIT  = 20;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [plct_pkg::CFG_W-1:0] cfg_wdata;

    plct_item_if #(.INDEX_BITS(INDEX_BITS)) item_ch ();
    plct_result_if                          result_ch ();

    paged_lru_cache_tracker_top #(
        .WAYS       (WAYS),
        .PAGE_ITEMS (PAGE_ITEMS),
        .INDEX_BITS (INDEX_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // bench copy of the tracker state and the cache_ways register
    logic [plct_pkg::PAGE_OUT_W-1:0] trk_page [WAYS];
    logic                            trk_valid [WAYS];
    logic [2:0]                      trk_age [WAYS];
    logic [plct_pkg::CFG_W-1:0]      ways_cfg;

    logic [INDEX_BITS-1:0] pending_index [$];
    plct_pkg::result_t     expected_words [$];

    int  mismatch_count;
    int  cycle_count;
    int  sender_gap;
    int  receiver_hold;
    bit  idling_enabled;
    bit  long_hold_request;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one lookup of the lru page tracker, returns the expected result word
    function automatic plct_pkg::result_t lru_access(input logic [INDEX_BITS-1:0] idx);
        logic [plct_pkg::PAGE_OUT_W-1:0] page;
        int                              found;
        int                              victim;
        int                              target;
        int                              count;
        int                              cap;
        logic [2:0]                      rank;
        logic [2:0]                      best;
        plct_pkg::result_t               r;
        page   = plct_pkg::PAGE_OUT_W'(idx / PAGE_ITEMS);
        found  = -1;
        victim = -1;
        target = -1;
        count  = 0;
        best   = '0;
        r      = '0;
        // zero acts as one, large values saturate
        if (ways_cfg == 0)
            cap = 1;
        else if (ways_cfg > WAYS)
            cap = WAYS;
        else
            cap = ways_cfg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (trk_valid[w])
            begin
                count++;
                if (trk_page[w] == page && found < 0)
                    found = w;
            end
        end
        if (found >= 0)
        begin
            // hit: younger ways age, the hit way becomes most recent
            rank  = trk_age[found];
            r.hit = 1'b1;
            for (int w = 0; w < WAYS; w++)
                if (trk_valid[w] && trk_age[w] < rank)
                    trk_age[w]++;
            trk_age[found] = '0;
        end
        else
        begin
            // miss on a full cache: evict the oldest valid way, reuse it
            if (count >= cap)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (trk_valid[w] && (victim < 0 || trk_age[w] > best))
                    begin
                        victim = w;
                        best   = trk_age[w];
                    end
                end
                if (victim >= 0)
                begin
                    r.evicted      = 1'b1;
                    r.evicted_page = trk_page[victim];
                    trk_valid[victim] = 1'b0;
                    target = victim;
                end
            end
            // otherwise the lowest free way
            if (target < 0)
            begin
                for (int w = WAYS - 1; w >= 0; w--)
                    if (!trk_valid[w])
                        target = w;
            end
            for (int w = 0; w < WAYS; w++)
                if (trk_valid[w])
                    trk_age[w]++;
            if (target >= 0)
            begin
                trk_page[target]  = page;
                trk_valid[target] = 1'b1;
                trk_age[target]   = '0;
            end
        end
        r.page_number = page;
        return r;
    endfunction

    // driver: offer pending item words, random gaps between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                expected_words = {expected_words, lru_access(item_ch.item_index)};
            if (!item_ch.valid || item_ch.ready)
            begin
                if (sender_gap > 0)
                begin
                    sender_gap--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_index.size() > 0)
                begin
                    item_ch.valid      <= 1'b1;
                    item_ch.item_index <= pending_index.pop_front();
                    if (idling_enabled && $urandom_range(0, 7) == 0)
                        sender_gap = $urandom_range(1, 17);
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare result words, random and long back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with none expected: page_number %0d",
                           result_ch.page_number);
                    mismatch_count++;
                end
                else
                begin
                    plct_pkg::result_t exp_word;
                    exp_word = expected_words.pop_front();
                    if (result_ch.hit !== exp_word.hit)
                    begin
                        $error("hit mismatch: expected %0d actual %0d",
                               exp_word.hit, result_ch.hit);
                        mismatch_count++;
                    end
                    if (result_ch.page_number !== exp_word.page_number)
                    begin
                        $error("page_number mismatch: expected %0d actual %0d",
                               exp_word.page_number, result_ch.page_number);
                        mismatch_count++;
                    end
                    if (result_ch.evicted !== exp_word.evicted)
                    begin
                        $error("evicted mismatch: expected %0d actual %0d",
                               exp_word.evicted, result_ch.evicted);
                        mismatch_count++;
                    end
                    if (result_ch.evicted_page !== exp_word.evicted_page)
                    begin
                        $error("evicted_page mismatch: expected %0d actual %0d",
                               exp_word.evicted_page, result_ch.evicted_page);
                        mismatch_count++;
                    end
                end
            end
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                receiver_hold     = LONG_HOLD;
                result_ch.ready <= 1'b0;
            end
            else if (receiver_hold > 0)
            begin
                receiver_hold--;
                result_ch.ready <= 1'b0;
            end
            else if (idling_enabled && $urandom_range(0, 7) == 0)
            begin
                receiver_hold = $urandom_range(0, 16);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL paged_lru_cache_tracker_top");
        $finish;
    end

    // append one item word to the pending queue
    task automatic add_index(input logic [INDEX_BITS-1:0] value);
        pending_index = {pending_index, value};
    endtask

    // wait until every word is through and the pipeline is empty
    task automatic wait_drained();
        while (pending_index.size() != 0 || item_ch.valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_cache_ways(input logic [plct_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ways_cfg = value;
    endtask

    // random words: mostly a small set of pages around a base, some anywhere
    task automatic queue_random(input int count, input int pool);
        int base;
        int idx;
        base = $urandom_range(0, MAX_PAGE - pool);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                idx = $urandom() & MAX_INDEX;
            else
                idx = (base + $urandom_range(0, pool - 1)) * PAGE_ITEMS
                      + $urandom_range(0, PAGE_ITEMS - 1);
            if (idx > MAX_INDEX)
                idx = MAX_INDEX;
            add_index(idx[INDEX_BITS-1:0]);
        end
    endtask

    // stimulus sequence
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        item_ch.valid      = 1'b0;
        item_ch.item_index = '0;
        result_ch.ready    = 1'b0;
        mismatch_count     = 0;
        sender_gap         = 0;
        receiver_hold      = 0;
        idling_enabled     = 1'b1;
        long_hold_request  = 1'b0;
        ways_cfg           = plct_pkg::CACHE_WAYS_RST;
        for (int w = 0; w < WAYS; w++)
        begin
            trk_page[w]  = '0;
            trk_valid[w] = 1'b0;
            trk_age[w]   = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset capacity: edges of the index, same-page hits, fill and evict
        add_index(16'd0);
        add_index(16'd9);
        add_index(16'd10);
        add_index(16'hFFFF);
        add_index(16'd65530);
        add_index(16'd65529);
        add_index(16'd20);
        add_index(16'd30);
        add_index(16'd40);
        add_index(16'd50);
        add_index(16'd1);
        add_index(16'd80);
        add_index(16'd90);
        add_index(16'd15);
        add_index(16'd0);
        wait_drained();

        // capacity zero behaves as one
        write_cache_ways(4'd0);
        add_index(16'd100);
        add_index(16'd105);
        add_index(16'd110);
        add_index(16'd100);
        queue_random(40, 3);
        wait_drained();

        // capacity above the way count saturates
        write_cache_ways(4'd15);
        add_index(16'd200);
        add_index(16'd210);
        add_index(16'd220);
        add_index(16'd230);
        add_index(16'd240);
        add_index(16'd250);
        queue_random(80, 12);
        wait_drained();

        // fill all ways, then lower the capacity while full
        write_cache_ways(4'd8);
        queue_random(60, 14);
        wait_drained();
        write_cache_ways(4'd2);
        queue_random(60, 4);
        wait_drained();

        write_cache_ways(4'd1);
        queue_random(40, 2);
        wait_drained();

        // long receiver stall while the sender keeps going
        write_cache_ways(4'd3);
        queue_random(80, 5);
        long_hold_request = 1'b1;
        wait_drained();

        // last part runs without idling
        idling_enabled = 1'b0;
        write_cache_ways(4'd5);
        queue_random(80, 8);
        wait_drained();

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("PASS paged_lru_cache_tracker_top");
        else
            $display("FAIL paged_lru_cache_tracker_top");
        $finish;
    end

endmodule

### files.f
rtl/plct_pkg.sv
rtl/plct_if.sv
rtl/plct_page_div.sv
rtl/plct_lru_core.sv
rtl/paged_lru_cache_tracker_top.sv
tb/sv/paged_lru_cache_tracker_top_tb.sv
